>>> rtl/core/itp_pkg.sv
// itp_pkg: shared types, constants and helper functions for the infix to
// postfix converter; no dependencies
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // stack entry codes
    localparam logic [2:0] CODE_PLUS   = 3'd0;
    localparam logic [2:0] CODE_MINUS  = 3'd1;
    localparam logic [2:0] CODE_MUL    = 3'd2;
    localparam logic [2:0] CODE_DIV    = 3'd3;
    localparam logic [2:0] CODE_LPAREN = 3'd4;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TERM   = 8'h00;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic       rd;
        logic [2:0] code;
    } stk_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [2:0]       rd_code;
        logic             ovf;
    } stk_stat_t;

    function automatic logic [1:0] prec_of(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] char_of(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_PLUS:  c = CH_PLUS;
            CODE_MINUS: c = CH_MINUS;
            CODE_MUL:   c = CH_MUL;
            CODE_DIV:   c = CH_DIV;
            default:    c = CH_LPAREN;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/itp_stack.sv
// itp_stack: operator stack memory with fill count and sticky overflow flag
// depends on itp_pkg
module itp_stack (
    input  logic              aclk,
    input  logic              aresetn,
    input  itp_pkg::stk_cmd_t cmd,
    output itp_pkg::stk_stat_t stat
);
    import itp_pkg::*;

    logic [2:0]       mem [STACK_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [2:0]       rd_reg;
    logic             not_full;
    logic [CNT_W-1:0] count_m1;

    assign not_full = count_reg < CNT_W'(STACK_DEPTH);
    assign count_m1 = count_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.clear) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.push) begin
            if (not_full) begin
                count_reg <= count_reg + CNT_W'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end else if (cmd.pop) begin
            count_reg <= count_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && not_full) begin
            mem[count_reg[STK_AW-1:0]] <= cmd.code;
        end
        // top of stack read
        if (cmd.rd) begin
            rd_reg <= mem[count_m1[STK_AW-1:0]];
        end
    end

    assign stat.count   = count_reg;
    assign stat.rd_code = rd_reg;
    assign stat.ovf     = ovf_reg;

endmodule

>>> rtl/core/infix_to_postfix_converter.sv
// infix_to_postfix_converter: shunting-yard conversion of a character stream
// to postfix; depends on itp_pkg and itp_stack
//
//  channel | dir | beat contents
//  s_      | in  | tdata[7:0] symbol, tuser end_of_input
//  m_      | out | tdata[7:0] out_char, tlast last,
//          |     | tuser[0] end_of_expression, tuser[1] overflow
//
// an operand or '(' passes idle, decide, finish; an operator, ')' or end marker
// also passes decide and check for each stacked entry it examines (top read from
// the stack memory, then compare), plus one more finish step when anything was
// popped to release the held last char. ready is high only in the idle state; a
// full output register stalls the sequencer at the point it must emit. reset is
// synchronous; the stack memory is not cleared, only its fill count and flag.
module infix_to_postfix_converter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] end_of_expression, [1] overflow
);
    import itp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        K_OPERAND,
        K_OP,
        K_LPAREN,
        K_RPAREN,
        K_END
    } kind_t;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] sym_reg, sym_next;
    logic [1:0] opc_reg, opc_next;
    logic [7:0] pend_reg, pend_next;
    logic       pend_valid_reg, pend_valid_next;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic [1:0] m_tuser_reg;

    logic       out_free;
    logic       out_load;
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] out_user;
    logic       pop_cond;

    stk_cmd_t   stk_cmd;
    stk_stat_t  stk_stat;

    itp_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        case (kind_reg)
            K_END:    pop_cond = 1'b1;
            K_OP:     pop_cond = prec_of(stk_stat.rd_code) >= prec_of({1'b0, opc_reg});
            K_RPAREN: pop_cond = stk_stat.rd_code != CODE_LPAREN;
            default:  pop_cond = 1'b0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sym_next        = sym_reg;
        opc_next        = opc_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        stk_cmd         = '0;
        out_load        = 1'b0;
        out_char        = pend_reg;
        out_last        = 1'b0;
        out_user        = 2'b00;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sym_next   = s_tdata;
                    state_next = ST_DECIDE;
                    if (s_tuser) begin
                        kind_next = K_END;
                    end else begin
                        case (s_tdata)
                            CH_PLUS: begin
                                kind_next = K_OP;
                                opc_next  = CODE_PLUS[1:0];
                            end
                            CH_MINUS: begin
                                kind_next = K_OP;
                                opc_next  = CODE_MINUS[1:0];
                            end
                            CH_MUL: begin
                                kind_next = K_OP;
                                opc_next  = CODE_MUL[1:0];
                            end
                            CH_DIV: begin
                                kind_next = K_OP;
                                opc_next  = CODE_DIV[1:0];
                            end
                            CH_LPAREN: kind_next = K_LPAREN;
                            CH_RPAREN: kind_next = K_RPAREN;
                            default:   kind_next = K_OPERAND;
                        endcase
                    end
                end
            end
            ST_DECIDE: begin
                if (kind_reg inside {K_OPERAND, K_LPAREN} || stk_stat.count == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    stk_cmd.rd = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (pop_cond) begin
                    // the held char goes out once the next pop proves it is not last
                    if (!pend_valid_reg || out_free) begin
                        out_load        = pend_valid_reg;
                        pend_next       = char_of(stk_stat.rd_code);
                        pend_valid_next = 1'b1;
                        stk_cmd.pop     = 1'b1;
                        state_next      = ST_DECIDE;
                    end
                end else begin
                    // ')' discards its matching '('
                    stk_cmd.pop = (kind_reg == K_RPAREN);
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_last        = (kind_reg != K_END);
                        pend_valid_next = 1'b0;
                    end
                end else begin
                    case (kind_reg)
                        K_OPERAND: begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                out_char   = sym_reg;
                                out_last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        K_OP: begin
                            stk_cmd.push = 1'b1;
                            stk_cmd.code = {1'b0, opc_reg};
                            state_next   = ST_IDLE;
                        end
                        K_LPAREN: begin
                            stk_cmd.push = 1'b1;
                            stk_cmd.code = CODE_LPAREN;
                            state_next   = ST_IDLE;
                        end
                        K_END: begin
                            if (out_free) begin
                                out_load      = 1'b1;
                                out_char      = CH_TERM;
                                out_last      = 1'b1;
                                out_user      = {stk_stat.ovf, 1'b1};
                                stk_cmd.clear = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        sym_reg  <= sym_next;
        opc_reg  <= opc_next;
        pend_reg <= pend_next;
        if (out_load) begin
            m_tdata_reg <= out_char;
            m_tlast_reg <= out_last;
            m_tuser_reg <= out_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_pend_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg != ST_IDLE))
        else $error("held char left over in idle");

    a_term_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("terminator not marked last");

    a_ovf_on_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("overflow reported off the terminator");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_stat.count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECIDE))
        else $error("accepted beat not decoded");

endmodule

>>> tb/tb_infix_to_postfix_converter.sv
// tb_infix_to_postfix_converter: stream-level test of the shunting-yard converter,
// with an internal operator-stack predictor checking every result beat in order
// depends on itp_pkg and infix_to_postfix_converter
module tb_infix_to_postfix_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       eoe;
        logic       ovf;
    } postfix_beat_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] symbol
    logic       s_tuser  = 1'b0;    // [0] end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;
    logic [1:0] m_tuser;            // [0] end_of_expression, [1] overflow

    // predictor state
    logic [2:0]    op_stack [0:STACK_DEPTH-1];
    int            op_depth        = 0;
    bit            overflow_sticky = 1'b0;
    postfix_beat_t staged;
    bit            staged_valid;
    postfix_beat_t pending_postfix [$];

    logic [7:0] code_glyph [0:4] = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_LPAREN};
    int         code_rank  [0:4] = '{1, 1, 2, 2, 0};

    int bad_fields  = 0;
    int burst_left  = 0;
    int hold_reqs   = 0;
    int holds_taken = 0;
    int hold_left   = 0;
    int ready_mode  = 0;
    int mode_left   = 0;

    infix_to_postfix_converter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // ---------------- predictor ----------------

    // the previous beat of this item goes out without last; the final one gets it later
    function automatic void stage_beat(input logic [7:0] c, input logic eoe, input logic ovf);
        if (staged_valid)
            pending_postfix.push_back(staged);
        staged       = '{c, 1'b0, eoe, ovf};
        staged_valid = 1'b1;
    endfunction

    function automatic void pop_to_output();
        op_depth--;
        stage_beat(code_glyph[op_stack[op_depth]], 1'b0, 1'b0);
    endfunction

    function automatic void push_op(input logic [2:0] code);
        if (op_depth >= STACK_DEPTH) begin
            overflow_sticky = 1'b1;
        end else begin
            op_stack[op_depth] = code;
            op_depth++;
        end
    endfunction

    function automatic void convert_symbol(input logic [7:0] sym, input logic eoi);
        logic [2:0] code;
        bit         is_op;
        is_op        = 1'b1;
        code         = CODE_PLUS;
        staged_valid = 1'b0;
        case (sym)
            CH_PLUS:  code = CODE_PLUS;
            CH_MINUS: code = CODE_MINUS;
            CH_MUL:   code = CODE_MUL;
            CH_DIV:   code = CODE_DIV;
            default:  is_op = 1'b0;
        endcase
        if (eoi) begin
            while (op_depth > 0)
                pop_to_output();
            stage_beat(CH_TERM, 1'b1, overflow_sticky);
            overflow_sticky = 1'b0;
        end else if (is_op) begin
            while (op_depth > 0 && code_rank[op_stack[op_depth-1]] >= code_rank[code])
                pop_to_output();
            push_op(code);
        end else if (sym == CH_LPAREN) begin
            push_op(CODE_LPAREN);
        end else if (sym == CH_RPAREN) begin
            while (op_depth > 0 && op_stack[op_depth-1] != CODE_LPAREN)
                pop_to_output();
            if (op_depth > 0)
                op_depth--;
        end else begin
            stage_beat(sym, 1'b0, 1'b0);
        end
        if (staged_valid) begin
            staged.last = 1'b1;
            pending_postfix.push_back(staged);
        end
    endfunction

    // ---------------- checker ----------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            bad_fields++;
        end
    endfunction

    always @(posedge aclk) begin
        postfix_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_postfix.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual char=%h last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                bad_fields++;
            end else begin
                want = pending_postfix.pop_front();
                check_field("out_char", want.ch, m_tdata);
                check_field("last", {7'd0, want.last}, {7'd0, m_tlast});
                check_field("end_of_expression", {7'd0, want.eoe}, {7'd0, m_tuser[0]});
                check_field("overflow", {7'd0, want.ovf}, {7'd0, m_tuser[1]});
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            hold_left   <= 0;
            holds_taken <= 0;
            ready_mode  <= 0;
            mode_left   <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != hold_reqs) begin
            // long hold-off so the block backs up into its input
            holds_taken <= holds_taken + 1;
            hold_left   <= 400;
            m_tready    <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((mode_left % 5) < 3);
            endcase
        end
    end

    // ---------------- sender ----------------

    task automatic send_beat(input logic [7:0] sym, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        burst_left--;
        convert_symbol(sym, eoi);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_beat(text[i], 1'b0);
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
            return 8'("a" + $urandom_range(0, 25));
        c = 8'($urandom_range(0, 255));
        while (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
               c == CH_LPAREN || c == CH_RPAREN)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] noise_symbol();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(0, 255));
            1:       return CH_RPAREN;
            default: return code_glyph[$urandom_range(0, 4)];
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_operand_extremes();
        send_beat(8'h00, 1'b0);     // zero is an operand, not a terminator
        send_beat(8'hFF, 1'b0);
        send_beat(8'hA5, 1'b1);     // symbol ignored on the end marker
    endtask

    task automatic test_precedence();
        send_text("a+b*c-d/e");
        send_beat(8'h5A, 1'b1);
    endtask

    task automatic test_unmatched_parens();
        // ')' on empty stack, ')' with no '(' left, '(' still open at the end
        send_text(")a-(b))*(c");
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_stack_overflow();
        repeat (30) send_beat(CH_LPAREN, 1'b0);
        send_text("a+((");          // last '(' lands on a full stack
        send_beat(CH_PLUS, 1'b0);   // pops nothing, push dropped
        send_beat(8'h3C, 1'b1);
    endtask

    task automatic test_output_hold();
        hold_reqs++;
        repeat (24) send_beat(random_operand(), 1'b0);
        send_text("x*y");
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_random_expressions();
        int sent;
        int opens;
        int terms;
        sent = 0;
        while (sent < 90) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(noise_symbol(), $urandom_range(0, 9) == 0);
                    sent++;
                end
            end else begin
                opens = 0;
                terms = $urandom_range(1, 6);
                for (int k = 0; k < terms; k++) begin
                    if (k > 0) begin
                        send_beat(code_glyph[$urandom_range(0, 3)], 1'b0);
                        sent++;
                    end
                    while ($urandom_range(0, 3) == 0) begin
                        send_beat(CH_LPAREN, 1'b0);
                        opens++;
                        sent++;
                    end
                    send_beat(random_operand(), 1'b0);
                    sent++;
                    while (opens > 0 && $urandom_range(0, 2) == 0) begin
                        send_beat(CH_RPAREN, 1'b0);
                        opens--;
                        sent++;
                    end
                end
                // now and then leave a '(' open for the flush to emit
                if ($urandom_range(0, 4) != 0) begin
                    while (opens > 0) begin
                        send_beat(CH_RPAREN, 1'b0);
                        opens--;
                        sent++;
                    end
                end
                send_beat(8'($urandom_range(0, 255)), 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operand_extremes();
        test_precedence();
        test_unmatched_parens();
        test_stack_overflow();
        test_output_hold();
        test_random_expressions();
        s_tvalid <= 1'b0;
        while (pending_postfix.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (bad_fields == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
